// ===== src/bspline_basis_evaluate_macros.svh =====
// Assertion macros shared by the checker of the B-spline basis evaluator
`ifndef BSPLINE_BASIS_EVALUATE_MACROS_SVH
`define BSPLINE_BASIS_EVALUATE_MACROS_SVH

// Same-cycle implication, quiet while reset is held
`define BBE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held
`define BBE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bbe_pkg.sv =====
// Types and fixed constants of the B-spline basis evaluator
package bbe_pkg;

  localparam int KNOT_W     = 32;          // signed Q16.16 knots and samples
  localparam int DEN_W      = KNOT_W + 1;  // span of two knots
  localparam int KIDX_W     = 6;           // knot_index field
  localparam int BIDX_W     = 6;           // basis_index field
  localparam int DEG_REG_W  = 3;
  localparam int CNT_REG_W  = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DEG_REG_W-1:0] DEG_RST = 3'd3;
  localparam logic [CNT_REG_W-1:0] CNT_RST = 7'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOTS  = 1'b1;

  // request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_RD_T0, S_RD_TN, S_DECIDE, S_SRCH, S_SETUP,
    S_L0A, S_L0B, S_F0, S_F1, S_F2, S_F3, S_F4, S_DIV1, S_DIV2,
    S_MUL1, S_MUL2, S_SUM, S_DROP, S_EMIT, S_SINGLE
  } state_t;

  // which knot register takes the read data
  typedef enum logic [2:0] {
    CAP_NONE, CAP_T0, CAP_TN, CAP_KA, CAP_KB, CAP_KC, CAP_KD
  } cap_t;

  // source of an emitted basis value
  typedef enum logic [1:0] {
    VSEL_ZERO, VSEL_ONE, VSEL_Q
  } vsel_t;

  typedef struct packed {
    logic              ld_x;
    cap_t              cap;
    logic              div_start;
    logic              div_sel;
    logic              cap_s1;
    logic              cap_s2;
    logic              mul1;
    logic              mul2;
    logic              q_lvl0;
    logic              q_push;
    logic              q_shift;
    logic              out_load;
    vsel_t             val_sel;
    logic [BIDX_W-1:0] out_idx;
    logic              out_last;
    logic              out_oor;
  } cmd_t;

  typedef struct packed {
    logic lt_t0;
    logic gt_tn;
    logic eq_t0;
    logic eq_tn;
    logic rd_gt_x;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== src/bbe_if.sv =====
// Request and result channel interfaces of the B-spline basis evaluator
interface bbe_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [bbe_pkg::KIDX_W-1:0]       knot_index;
  logic signed [bbe_pkg::KNOT_W-1:0] knot_value;
  logic signed [bbe_pkg::KNOT_W-1:0] sample_x;

  modport source (output valid, kind, knot_index, knot_value, sample_x, input ready);
  modport sink   (input valid, kind, knot_index, knot_value, sample_x, output ready);
endinterface

interface bbe_res_if #(parameter int VAL_W = 17);
  logic                       valid;
  logic                       ready;
  logic [bbe_pkg::BIDX_W-1:0] basis_index;
  logic [VAL_W-1:0]           basis_value;
  logic                       last_of_run;
  logic                       out_of_range;

  modport source (output valid, basis_index, basis_value, last_of_run, out_of_range,
                  input ready);
  modport sink   (input valid, basis_index, basis_value, last_of_run, out_of_range,
                  output ready);
endinterface

// ===== src/bbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bbe_div.sv =====
// Restoring divider for ramp coefficients: quotient num/den with num <= den
module bbe_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bbe_pkg::DEN_W-1:0] num,
  input  logic [bbe_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [FRAC_BITS:0]        quo
);

  localparam int DW   = bbe_pkg::DEN_W;
  localparam int CNTW = $clog2(FRAC_BITS + 2);

  logic [DW:0]        rem_r;
  logic [DW-1:0]      den_r;
  logic [FRAC_BITS:0] quo_r;
  logic [CNTW-1:0]    cnt_r;
  logic               busy_r;
  logic               ge;
  logic [DW:0]        rem_sub;

  // one quotient bit a cycle, integer bit first
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(FRAC_BITS + 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[DW-1:0], 1'b0};
      quo_r <= {quo_r[FRAC_BITS-1:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== src/bbe_dp.sv =====
// Datapath: knot registers, ramp divider, level multipliers, value queue, output register
module bbe_dp #(
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bbe_pkg::cmd_t                      cmd,
  input  logic [$clog2(2*MAX_DEGREE+1)-1:0]  q_pos,
  input  logic signed [bbe_pkg::KNOT_W-1:0]  sample_x,
  input  logic [bbe_pkg::KNOT_W-1:0]         rd_data,
  input  logic                               out_ready,
  output bbe_pkg::sts_t                      sts,
  output logic                               out_valid,
  output logic [bbe_pkg::BIDX_W-1:0]         out_basis_index,
  output logic [FRAC_BITS:0]                 out_basis_value,
  output logic                               out_last,
  output logic                               out_oor
);

  localparam int VW = FRAC_BITS + 1;
  localparam int NQ = 2 * MAX_DEGREE + 1;
  localparam int KW = bbe_pkg::KNOT_W;
  localparam int DW = bbe_pkg::DEN_W;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic signed [KW-1:0] x_r, t0_r, tn_r, ka_r, kb_r, kc_r, kd_r;
  logic signed [KW-1:0] rd_s, lo, hi;
  logic [VW-1:0]        s1_r, s2_r, s2c, quo, lvl0_v, new_v, out_v;
  logic [2*VW-1:0]      p1_r, p2_r;
  logic [2*VW:0]        psum, pshift;
  logic [VW-1:0]        q_r [NQ];
  logic [VW-1:0]        q_nxt [NQ];
  logic                 ramp_ok, div_busy;
  logic [DW-1:0]        d_num, d_den;
  logic                 out_valid_r;
  logic [bbe_pkg::BIDX_W-1:0] oidx_r;
  logic [VW-1:0]        oval_r;
  logic                 olast_r, ooor_r;

  assign rd_s = $signed(rd_data);

  // sample and knot capture
  always_ff @(posedge clk) begin
    if (cmd.ld_x) begin
      x_r <= sample_x;
    end
    case (cmd.cap)
      bbe_pkg::CAP_T0: t0_r <= rd_s;
      bbe_pkg::CAP_TN: tn_r <= rd_s;
      bbe_pkg::CAP_KA: ka_r <= rd_s;
      bbe_pkg::CAP_KB: kb_r <= rd_s;
      bbe_pkg::CAP_KC: kc_r <= rd_s;
      bbe_pkg::CAP_KD: kd_r <= rd_s;
      default: ;
    endcase
  end

  // ramp (x - lo) / (hi - lo), forced to zero outside lo..hi or on an empty interval
  assign lo      = cmd.div_sel ? kc_r : ka_r;
  assign hi      = cmd.div_sel ? kd_r : kb_r;
  assign ramp_ok = (lo < hi) && (lo <= x_r) && (x_r <= hi);
  assign d_num   = ramp_ok ? (DW'({x_r[KW-1], x_r}) - DW'({lo[KW-1], lo})) : '0;
  assign d_den   = ramp_ok ? (DW'({hi[KW-1], hi}) - DW'({lo[KW-1], lo})) : DW'(1);

  bbe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (d_num),
    .den   (d_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // coefficient capture and the two products of one level step
  assign s2c = ONE - s2_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_s1) begin
      s1_r <= quo;
    end
    if (cmd.cap_s2) begin
      s2_r <= quo;
    end
    if (cmd.mul1) begin
      p1_r <= s1_r * q_r[0];
    end
    if (cmd.mul2) begin
      p2_r <= s2c * q_r[1];
    end
  end

  // truncate and saturate at 1.0
  assign psum   = {1'b0, p1_r} + {1'b0, p2_r};
  assign pshift = psum >> FRAC_BITS;
  assign new_v  = (pshift > (2*VW+1)'(ONE)) ? ONE : VW'(pshift);

  // level-0 indicator of the half-open interval
  assign lvl0_v = ((ka_r <= x_r) && (x_r < rd_s)) ? ONE : '0;

  // value queue: oldest entries at the head, new level values appended at the tail
  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (cmd.q_push || cmd.q_shift) begin
      for (int i = 0; i < NQ - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    if (cmd.q_push) begin
      q_nxt[q_pos] = new_v;
    end
    if (cmd.q_lvl0) begin
      q_nxt[q_pos] = lvl0_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NQ; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // result register
  always_comb begin
    case (cmd.val_sel)
      bbe_pkg::VSEL_ONE: out_v = ONE;
      bbe_pkg::VSEL_Q:   out_v = q_r[0];
      default:           out_v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oidx_r  <= cmd.out_idx;
      oval_r  <= out_v;
      olast_r <= cmd.out_last;
      ooor_r  <= cmd.out_oor;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_basis_index = oidx_r;
  assign out_basis_value = oval_r;
  assign out_last        = olast_r;
  assign out_oor         = ooor_r;

  // status to the controller
  assign sts.lt_t0    = x_r < t0_r;
  assign sts.gt_tn    = x_r > tn_r;
  assign sts.eq_t0    = x_r == t0_r;
  assign sts.eq_tn    = x_r == tn_r;
  assign sts.rd_gt_x  = rd_s > x_r;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ===== src/bbe_ctrl.sv =====
// Controller: configuration registers, span search and Cox-de Boor sequencing
module bbe_ctrl #(
  parameter int MAX_KNOTS  = 64,
  parameter int MAX_DEGREE = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_kind,
  input  logic [bbe_pkg::KIDX_W-1:0]           in_knot_index,
  output logic                                 in_ready,
  output logic                                 ram_we,
  output logic [$clog2(MAX_KNOTS)-1:0]         ram_raddr,
  output logic [$clog2(2*MAX_DEGREE+1)-1:0]    q_pos,
  output bbe_pkg::cmd_t                        cmd,
  input  bbe_pkg::sts_t                        sts
);

  localparam int KW = $clog2(MAX_KNOTS);
  localparam int IW = $clog2(MAX_KNOTS + 1);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int CW = $clog2(2 * MAX_DEGREE + 2);
  localparam int QW = $clog2(2 * MAX_DEGREE + 1);
  localparam int BW = bbe_pkg::BIDX_W;

  bbe_pkg::state_t state_r, state_nxt;

  logic [bbe_pkg::DEG_REG_W-1:0] deg_r;
  logic [bbe_pkg::CNT_REG_W-1:0] kcnt_r;
  logic [IW-1:0] n_r, n_nxt, n_c;
  logic [DW-1:0] p_r, p_nxt, p_c;
  logic [IW-1:0] j_r, j_nxt, first_r, first_nxt, last_r, last_nxt;
  logic [DW-1:0] k_r, k_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  bbe_pkg::vsel_t sg_sel_r, sg_sel_nxt;
  logic [BW-1:0]  sg_idx_r, sg_idx_nxt;
  logic           sg_oor_r, sg_oor_nxt;

  logic          acc, eval_acc, too_few, oor, step_more, l0_done, emit_last;
  logic [IW-1:0] base, rd_idx, nbm1, u, last_c, first_c, emit_pos;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r  <= bbe_pkg::DEG_RST;
      kcnt_r <= bbe_pkg::CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bbe_pkg::CFG_DEGREE: deg_r  <= cfg_data[bbe_pkg::DEG_REG_W-1:0];
        bbe_pkg::CFG_KNOTS:  kcnt_r <= cfg_data[bbe_pkg::CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped knot count and degree
  always_comb begin
    if (32'(kcnt_r) < 4) begin
      n_c = IW'(4);
    end else if (32'(kcnt_r) > MAX_KNOTS) begin
      n_c = IW'(MAX_KNOTS);
    end else begin
      n_c = IW'(kcnt_r);
    end
    if (32'(deg_r) < 1) begin
      p_c = DW'(1);
    end else if (32'(deg_r) > MAX_DEGREE) begin
      p_c = DW'(MAX_DEGREE);
    end else begin
      p_c = DW'(deg_r);
    end
  end

  assign acc       = in_valid && in_ready;
  assign eval_acc  = acc && (in_kind == bbe_pkg::KIND_EVAL);
  assign too_few   = 32'(n_r) < (32'(p_r) + 32'd2);
  assign oor       = sts.lt_t0 || sts.gt_tn;
  assign nbm1      = n_r - IW'(p_r) - IW'(2);
  assign base      = first_r + j_r;
  assign emit_pos  = base;
  assign emit_last = emit_pos == last_r;
  assign step_more = (32'(j_r) + 32'(k_r) + 32'd1) < 32'(cnt_r);
  assign l0_done   = (32'(j_r) + 32'd1) == 32'(cnt_r);

  // span u and the run of supported indexes
  assign u       = j_r - IW'(1);
  assign last_c  = (u < nbm1) ? u : nbm1;
  assign first_c = (32'(last_c) >= 32'(p_r)) ? (last_c - IW'(p_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    cnt_r    <= cnt_nxt;
    sg_sel_r <= sg_sel_nxt;
    sg_idx_r <= sg_idx_nxt;
    sg_oor_r <= sg_oor_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbe_pkg::S_IDLE:   if (eval_acc) state_nxt = bbe_pkg::S_CHK;
      bbe_pkg::S_CHK:    state_nxt = too_few ? bbe_pkg::S_SINGLE : bbe_pkg::S_RD_T0;
      bbe_pkg::S_RD_T0:  state_nxt = bbe_pkg::S_RD_TN;
      bbe_pkg::S_RD_TN:  state_nxt = bbe_pkg::S_DECIDE;
      bbe_pkg::S_DECIDE: begin
        if (oor || sts.eq_t0 || sts.eq_tn) begin
          state_nxt = bbe_pkg::S_SINGLE;
        end else begin
          state_nxt = bbe_pkg::S_SRCH;
        end
      end
      bbe_pkg::S_SRCH:   if (sts.rd_gt_x) state_nxt = bbe_pkg::S_SETUP;
      bbe_pkg::S_SETUP:  state_nxt = bbe_pkg::S_L0A;
      bbe_pkg::S_L0A:    state_nxt = bbe_pkg::S_L0B;
      bbe_pkg::S_L0B:    state_nxt = l0_done ? bbe_pkg::S_F0 : bbe_pkg::S_L0A;
      bbe_pkg::S_F0:     state_nxt = bbe_pkg::S_F1;
      bbe_pkg::S_F1:     state_nxt = bbe_pkg::S_F2;
      bbe_pkg::S_F2:     state_nxt = bbe_pkg::S_F3;
      bbe_pkg::S_F3:     state_nxt = bbe_pkg::S_F4;
      bbe_pkg::S_F4:     state_nxt = bbe_pkg::S_DIV1;
      bbe_pkg::S_DIV1:   if (!sts.div_busy) state_nxt = bbe_pkg::S_DIV2;
      bbe_pkg::S_DIV2:   if (!sts.div_busy) state_nxt = bbe_pkg::S_MUL1;
      bbe_pkg::S_MUL1:   state_nxt = bbe_pkg::S_MUL2;
      bbe_pkg::S_MUL2:   state_nxt = bbe_pkg::S_SUM;
      bbe_pkg::S_SUM:    state_nxt = step_more ? bbe_pkg::S_F0 : bbe_pkg::S_DROP;
      bbe_pkg::S_DROP:   state_nxt = (k_r == p_r) ? bbe_pkg::S_EMIT : bbe_pkg::S_F0;
      bbe_pkg::S_EMIT:   if (sts.out_free && emit_last) state_nxt = bbe_pkg::S_IDLE;
      bbe_pkg::S_SINGLE: if (sts.out_free) state_nxt = bbe_pkg::S_IDLE;
      default:           state_nxt = bbe_pkg::S_IDLE;
    endcase
  end

  // outputs: handshake, knot reads and datapath commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    rd_idx    = '0;
    q_pos     = '0;
    case (state_r)
      bbe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ram_we   = acc && (in_kind == bbe_pkg::KIND_LOAD) &&
                   (32'(in_knot_index) < MAX_KNOTS);
        cmd.ld_x = eval_acc;
      end
      bbe_pkg::S_CHK:    rd_idx = '0;
      bbe_pkg::S_RD_T0: begin
        cmd.cap = bbe_pkg::CAP_T0;
        rd_idx  = n_r - IW'(1);
      end
      bbe_pkg::S_RD_TN:  cmd.cap = bbe_pkg::CAP_TN;
      bbe_pkg::S_DECIDE: rd_idx = IW'(1);
      bbe_pkg::S_SRCH:   rd_idx = j_r + IW'(1);
      bbe_pkg::S_SETUP:  rd_idx = first_r;
      bbe_pkg::S_L0A: begin
        cmd.cap = bbe_pkg::CAP_KA;
        rd_idx  = base + IW'(1);
      end
      bbe_pkg::S_L0B: begin
        cmd.q_lvl0 = 1'b1;
        q_pos      = QW'(j_r);
        rd_idx     = base + IW'(1);
      end
      bbe_pkg::S_F0:     rd_idx = base;
      bbe_pkg::S_F1: begin
        cmd.cap = bbe_pkg::CAP_KA;
        rd_idx  = base + IW'(k_r);
      end
      bbe_pkg::S_F2: begin
        cmd.cap = bbe_pkg::CAP_KB;
        rd_idx  = base + IW'(1);
      end
      bbe_pkg::S_F3: begin
        cmd.cap = bbe_pkg::CAP_KC;
        rd_idx  = base + IW'(k_r) + IW'(1);
      end
      bbe_pkg::S_F4: begin
        cmd.cap       = bbe_pkg::CAP_KD;
        cmd.div_start = 1'b1;
      end
      bbe_pkg::S_DIV1: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) begin
          cmd.cap_s1    = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      bbe_pkg::S_DIV2:   cmd.cap_s2 = !sts.div_busy;
      bbe_pkg::S_MUL1:   cmd.mul1 = 1'b1;
      bbe_pkg::S_MUL2:   cmd.mul2 = 1'b1;
      bbe_pkg::S_SUM: begin
        cmd.q_push = 1'b1;
        q_pos      = QW'(cnt_r - CW'(k_r));
      end
      bbe_pkg::S_DROP:   cmd.q_shift = 1'b1;
      bbe_pkg::S_EMIT: begin
        cmd.val_sel  = bbe_pkg::VSEL_Q;
        cmd.out_idx  = BW'(emit_pos);
        cmd.out_last = emit_last;
        cmd.out_load = sts.out_free;
        cmd.q_shift  = sts.out_free;
      end
      bbe_pkg::S_SINGLE: begin
        cmd.val_sel  = sg_sel_r;
        cmd.out_idx  = sg_idx_r;
        cmd.out_last = 1'b1;
        cmd.out_oor  = sg_oor_r;
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

  assign ram_raddr = rd_idx[KW-1:0];

  // sequencing counters
  always_comb begin
    n_nxt      = n_r;
    p_nxt      = p_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    cnt_nxt    = cnt_r;
    sg_sel_nxt = sg_sel_r;
    sg_idx_nxt = sg_idx_r;
    sg_oor_nxt = sg_oor_r;
    case (state_r)
      bbe_pkg::S_IDLE: begin
        if (eval_acc) begin
          n_nxt = n_c;
          p_nxt = p_c;
        end
      end
      bbe_pkg::S_CHK: begin
        sg_sel_nxt = bbe_pkg::VSEL_ZERO;
        sg_idx_nxt = '0;
        sg_oor_nxt = 1'b1;
      end
      bbe_pkg::S_DECIDE: begin
        j_nxt = IW'(1);
        if (oor) begin
          sg_sel_nxt = bbe_pkg::VSEL_ZERO;
          sg_idx_nxt = '0;
          sg_oor_nxt = 1'b1;
        end else if (sts.eq_t0) begin
          sg_sel_nxt = bbe_pkg::VSEL_ONE;
          sg_idx_nxt = '0;
          sg_oor_nxt = 1'b0;
        end else begin
          sg_sel_nxt = bbe_pkg::VSEL_ONE;
          sg_idx_nxt = BW'(nbm1);
          sg_oor_nxt = 1'b0;
        end
      end
      bbe_pkg::S_SRCH: begin
        if (sts.rd_gt_x) begin
          last_nxt  = last_c;
          first_nxt = first_c;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      bbe_pkg::S_SETUP: begin
        cnt_nxt = CW'(last_r - first_r + IW'(p_r) + IW'(1));
        j_nxt   = '0;
      end
      bbe_pkg::S_L0B: begin
        if (l0_done) begin
          j_nxt = '0;
          k_nxt = DW'(1);
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      bbe_pkg::S_SUM:    j_nxt = step_more ? (j_r + IW'(1)) : '0;
      bbe_pkg::S_DROP:   k_nxt = k_r + DW'(1);
      bbe_pkg::S_EMIT:   if (sts.out_free) j_nxt = j_r + IW'(1);
      default: ;
    endcase
  end

endmodule

// ===== src/bspline_basis_evaluate.sv =====
// Top level of the B-spline basis evaluator: channels, knot RAM, controller and datapath
// Usage:
//  in_req carries load and evaluate requests. A load (kind 0) writes one
//  knot into the knot RAM in the cycle it is accepted and gives no result.
//  An evaluate (kind 1) finds the knot span of sample_x and returns one
//  result per nonzero basis function on out_res, lowest index first, with
//  last_of_run on the final one; a sample outside the knots gives a single
//  result with out_of_range set.
//  An evaluate scans the knots in the span search, sets up the level-0
//  intervals, then runs the recursion steps, each with two ramp divisions
//  on the one shared divider, and then emits its results.
//  One request is in flight at a time; in_req.ready is high only while
//  the controller is idle. A result waits in the output register while
//  out_res.ready is low, and the sequencer holds until it is taken.
//  Reset clears the controller, the configuration (degree 3, eight knots)
//  and the output register; knots must be loaded before use.
//  The user must write configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module bspline_basis_evaluate #(
  parameter int MAX_KNOTS  = 64,
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]    cfg_data,
  bbe_req_if.sink                           in_req,
  bbe_res_if.source                         out_res
);

  localparam int KW = $clog2(MAX_KNOTS);
  localparam int QW = $clog2(2 * MAX_DEGREE + 1);

  bbe_pkg::cmd_t                cmd;
  bbe_pkg::sts_t                sts;
  logic                         ram_we;
  logic [KW-1:0]                ram_raddr;
  logic [bbe_pkg::KNOT_W-1:0]   ram_rdata;
  logic [QW-1:0]                q_pos;

  bbe_ram #(.WIDTH(bbe_pkg::KNOT_W), .DEPTH(MAX_KNOTS)) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (KW'(in_req.knot_index)),
    .wdata (in_req.knot_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbe_ctrl #(.MAX_KNOTS(MAX_KNOTS), .MAX_DEGREE(MAX_DEGREE)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_req.valid),
    .in_kind       (in_req.kind),
    .in_knot_index (in_req.knot_index),
    .in_ready      (in_req.ready),
    .ram_we        (ram_we),
    .ram_raddr     (ram_raddr),
    .q_pos         (q_pos),
    .cmd           (cmd),
    .sts           (sts)
  );

  bbe_dp #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .q_pos           (q_pos),
    .sample_x        (in_req.sample_x),
    .rd_data         (ram_rdata),
    .out_ready       (out_res.ready),
    .sts             (sts),
    .out_valid       (out_res.valid),
    .out_basis_index (out_res.basis_index),
    .out_basis_value (out_res.basis_value),
    .out_last        (out_res.last_of_run),
    .out_oor         (out_res.out_of_range)
  );

endmodule

// ===== src/bbe_chk.sv =====
// Port checker of the B-spline basis evaluator and its bind to the top level
`include "bspline_basis_evaluate_macros.svh"

module bbe_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bbe_pkg::BIDX_W-1:0] out_basis_index,
  input logic [FRAC_BITS:0]         out_basis_value,
  input logic                       out_last,
  input logic                       out_oor
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // a stalled result holds still
  `BBE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_basis_index) && $stable(out_basis_value) && $stable(out_last) && $stable(out_oor), "stalled result changed")

  // an evaluate request occupies the block
  `BBE_ASSERT_NXT(a_eval_busy, clk, rst_n, in_valid && in_ready && in_kind == bbe_pkg::KIND_EVAL, !in_ready, "ready after evaluate request")

  // a knot load leaves the block ready
  `BBE_ASSERT_NXT(a_load_ready, clk, rst_n, in_valid && in_ready && in_kind == bbe_pkg::KIND_LOAD, in_ready, "not ready after knot load")

  // out-of-range result is a single zero at index zero
  `BBE_ASSERT_IMP(a_oor_shape, clk, rst_n, out_valid && out_oor, out_last && out_basis_value == '0 && out_basis_index == '0, "malformed out-of-range result")

  // values never exceed 1.0
  `BBE_ASSERT_IMP(a_val_sat, clk, rst_n, out_valid, out_basis_value <= ONE, "basis value above one")

endmodule

bind bspline_basis_evaluate bbe_chk #(.FRAC_BITS(FRAC_BITS)) u_bbe_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .in_kind         (in_req.kind),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_basis_index (out_res.basis_index),
  .out_basis_value (out_res.basis_value),
  .out_last        (out_res.last_of_run),
  .out_oor         (out_res.out_of_range)
);

// ===== verif/tb.sv =====
// Self-checking testbench of the B-spline basis evaluator
module tb;

  localparam int  NKNOT     = 64;
  localparam int  FRAC      = 16;
  localparam longint ONE    = 64'sd1 << FRAC;
  localparam int  CYC_LIMIT = 4000000;

  typedef struct {
    logic [5:0]  idx;
    logic [16:0] val;
    logic        last;
    logic        oor;
  } basis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bbe_req_if req_if ();
  bbe_res_if res_if ();

  bspline_basis_evaluate i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_req(req_if), .out_res(res_if)
  );

  // shadow of the block's state
  logic signed [31:0] knot_copy [NKNOT];
  logic [2:0] deg_copy = bbe_pkg::DEG_RST;
  logic [6:0] cnt_copy = bbe_pkg::CNT_RST;

  basis_t basis_q [$];
  int errs = 0, n_req = 0, n_eval = 0, n_res = 0, n_oor = 0;
  int hold_rx = 0;
  bit quiet = 1'b0;
  int cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0; req_if.kind = bbe_pkg::KIND_LOAD; req_if.knot_index = '0;
    req_if.knot_value = '0; req_if.sample_x = '0; res_if.ready = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches, long hold-off
  always @(posedge clk) begin
    if (hold_rx > 0) begin
      res_if.ready <= 1'b0;
      hold_rx <= hold_rx - 1;
    end else if (quiet) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= 26);
    end
  end

  // result checker
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      n_res++;
      if (basis_q.size() == 0) begin
        errs++;
        $display("%0t: unexpected result idx=%0d val=%0d", $time, res_if.basis_index,
                 res_if.basis_value);
      end else begin
        e = basis_q.pop_front();
        if (res_if.basis_index !== e.idx || res_if.basis_value !== e.val ||
            res_if.last_of_run !== e.last || res_if.out_of_range !== e.oor) begin
          errs++;
          $display("%0t: mismatch exp %0d/%0d/%0b/%0b act %0d/%0d/%0b/%0b",
                   $time, e.idx, e.val, e.last, e.oor, res_if.basis_index,
                   res_if.basis_value, res_if.last_of_run, res_if.out_of_range);
        end
      end
    end
  end

  function automatic longint knot_at(int i);
    return longint'(knot_copy[i]);
  endfunction

  function automatic longint ramp(longint x, longint lo, longint hi);
    if (lo < hi && lo <= x && x <= hi) return ((x - lo) << FRAC) / (hi - lo);
    return 0;
  endfunction

  task automatic push_basis(int idx, longint val, bit last, bit oor);
    basis_t r;
    r.idx = idx[5:0]; r.val = val[16:0]; r.last = last; r.oor = oor;
    basis_q.insert(basis_q.size(), r);
  endtask

  // Cox-de Boor evaluation of the shadow knot table
  task automatic predict_basis(logic signed [31:0] xs);
    int n, p, nb, u, lst, fst, cnt;
    longint x, t0, tn, s1, s2, v;
    longint nv [16];
    n = cnt_copy < 4 ? 4 : (cnt_copy > NKNOT ? NKNOT : int'(cnt_copy));
    p = deg_copy < 1 ? 1 : int'(deg_copy);
    x = longint'(xs);
    t0 = knot_at(0);
    tn = knot_at(n - 1);
    // too few knots, or sample off the ends of the knot vector
    if (n < p + 2 || x < t0 || x > tn) begin
      push_basis(0, 0, 1, 1);
      n_oor++;
      return;
    end
    nb = n - p - 1;
    if (x == t0) begin
      push_basis(0, ONE, 1, 0);
      return;
    end
    if (x == tn) begin
      push_basis(nb - 1, ONE, 1, 0);
      return;
    end
    u = 0;
    for (int j = 1; j < n; j++) begin
      if (knot_at(j) > x) begin
        u = j - 1;
        break;
      end
    end
    lst = u < nb - 1 ? u : nb - 1;
    fst = lst >= p ? lst - p : 0;
    cnt = lst - fst + p + 1;
    for (int j = 0; j < cnt; j++)
      nv[j] = (knot_at(fst + j) <= x && x < knot_at(fst + j + 1)) ? ONE : 0;
    for (int k = 1; k <= p; k++) begin
      for (int j = 0; j + k < cnt; j++) begin
        s1 = ramp(x, knot_at(fst + j), knot_at(fst + j + k));
        s2 = ramp(x, knot_at(fst + j + 1), knot_at(fst + j + k + 1));
        v = (s1 * nv[j] + (ONE - s2) * nv[j + 1]) >>> FRAC;
        nv[j] = v > ONE ? ONE : v;
      end
    end
    for (int i = fst; i <= lst; i++) push_basis(i, nv[i - fst], i == lst, 0);
  endtask

  // one request; called just after a rising edge
  task automatic send_req(logic kind, logic [5:0] kidx, logic signed [31:0] kval,
                          logic signed [31:0] xs);
    int gap;
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.knot_index <= kidx;
    req_if.knot_value <= kval;
    req_if.sample_x <= xs;
    do @(posedge clk); while (!req_if.ready);
    n_req++;
    if (kind == bbe_pkg::KIND_LOAD) begin
      knot_copy[kidx] = kval;
    end else begin
      n_eval++;
      predict_basis(xs);
    end
    gap = (!quiet && $urandom_range(99) < 26) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_knot(int i, longint v);
    send_req(bbe_pkg::KIND_LOAD, i[5:0], v[31:0], '0);
  endtask

  task automatic eval_at(longint x);
    send_req(bbe_pkg::KIND_EVAL, '0, '0, x[31:0]);
  endtask

  // sender pauses until all results are in, then the block is idle
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (basis_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [bbe_pkg::CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[bbe_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bbe_pkg::CFG_DEGREE) deg_copy = val[2:0];
    else cnt_copy = val[6:0];
  endtask

  // sorted knots with repeats on the first n entries, or unsorted noise
  task automatic reload_knots(int n);
    longint v;
    bit noise;
    noise = ($urandom_range(99) < 15);
    v = longint'($signed($urandom_range(0, 32'h0008_0000))) - 64'sd262144;
    for (int i = 0; i < n; i++) begin
      if (noise) v = longint'($signed($urandom));
      else if (i > 0) v = v + ($urandom_range(99) < 25 ? 0 : $urandom_range(1, 200000));
      load_knot(i, v);
    end
  endtask

  task automatic eval_random(int n);
    longint t0, tn, x;
    int r;
    t0 = knot_at(0);
    tn = knot_at(n - 1);
    r = $urandom_range(99);
    if (r < 70 && tn > t0) x = t0 + longint'({$urandom, $urandom} % (tn - t0 + 1));
    else if (r < 80) x = knot_at($urandom_range(0, n - 1));
    else if (r < 90) x = $urandom_range(1) ? t0 - $urandom_range(1, 1000) : tn + 1;
    else x = longint'($signed($urandom));
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    eval_at(x);
  endtask

  // extremes of fields and registers, ends of the knot vector, clamping
  task automatic test_directed();
    quiet = 1'b1;
    for (int i = 0; i < NKNOT; i++) load_knot(i, longint'(i - 32) <<< FRAC);
    load_knot(0, -64'sd2147483648);
    load_knot(63, 64'sd2147483647);
    eval_at(-64'sd2147483648);            // first knot
    eval_at(-64'sd2147483648 + 1);
    eval_at(longint'(-25) <<< FRAC);      // last knot of eight
    eval_at((longint'(-25) <<< FRAC) + 1); // beyond last knot
    eval_at(-30 * 65536 + 12345);
    eval_at(64'sd2147483647);
    cfg_write(bbe_pkg::CFG_KNOTS, 127);   // clamps to the full table
    eval_at(64'sd2147483647);
    eval_at(0);
    eval_at(5 * 65536 + 777);
    cfg_write(bbe_pkg::CFG_DEGREE, 7);
    eval_at(3 * 65536 + 40000);
    eval_at(-29 * 65536);
    cfg_write(bbe_pkg::CFG_KNOTS, 0);     // clamps to four: too few for degree 7
    eval_at(-31 * 65536);
    cfg_write(bbe_pkg::CFG_DEGREE, 0);    // clamps to one
    eval_at(-31 * 65536 + 100);
    eval_at(-30 * 65536);
    cfg_write(bbe_pkg::CFG_KNOTS, 4);
    cfg_write(bbe_pkg::CFG_DEGREE, 2);
    eval_at(-30 * 65536 + 5);
    quiet = 1'b0;
    drain();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    cfg_write(bbe_pkg::CFG_DEGREE, 1);
    cfg_write(bbe_pkg::CFG_KNOTS, 12);
    reload_knots(12);
    hold_rx = 3000;
    for (int i = 0; i < 8; i++) eval_random(12);
    drain();
  endtask

  // random phases of configuration, knot table and samples
  task automatic test_random(int target);
    int n, d, c, k;
    k = 0;
    while (n_req < target) begin
      quiet = (k == 2);
      d = $urandom_range(0, 7);
      c = $urandom_range(99) < 15 ? $urandom_range(0, 127) : $urandom_range(4, 16);
      cfg_write(bbe_pkg::CFG_DEGREE, d);
      cfg_write(bbe_pkg::CFG_KNOTS, c);
      n = c < 4 ? 4 : (c > NKNOT ? NKNOT : c);
      if (n <= 24) reload_knots(n);
      if ($urandom_range(1)) load_knot($urandom_range(n, 63), longint'($signed($urandom)));
      repeat ($urandom_range(6, 12)) eval_random(n);
      k++;
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(210);
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d evaluations, %0d results (%0d out of range)",
             n_req, n_eval, n_res, n_oor);
    if (errs == 0 && basis_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== bspline_basis_evaluate.f =====
+incdir+src
src/bbe_pkg.sv
src/bbe_if.sv
src/bbe_ram.sv
src/bbe_div.sv
src/bbe_dp.sv
src/bbe_ctrl.sv
src/bspline_basis_evaluate.sv
src/bbe_chk.sv
verif/tb.sv
